FILE: rtl/pcvd_pkg.sv
`default_nettype none

package pcvd_pkg;

  typedef enum logic [2:0] {
    K_NUCLEUS      = 3'd0,
    K_ANTI_NUCLEUS = 3'd1,
    K_QUARK        = 3'd2,
    K_DIQUARK      = 3'd3,
    K_GLUON        = 3'd4,
    K_MESON        = 3'd5,
    K_BARYON       = 3'd6,
    K_UNCHECKED    = 3'd7
  } kind_t;

  // Reciprocals for division by constants; each quotient is exact or one low.
  localparam logic [31:0] RECIP_1E4 = 32'd3518437208;  // floor(2^45 / 10000)
  localparam logic [18:0] RECIP_1E3 = 19'd268435;      // floor(2^28 / 1000)
  // Exact for values below 10000.
  localparam logic [13:0] RECIP_DIG1000 = 14'd8389;     // >> 23
  localparam logic [12:0] RECIP_DIG100  = 13'd5243;     // >> 19
  localparam logic [15:0] RECIP_DIG10   = 16'd52429;    // >> 19

  localparam logic [31:0] MESON_K_SHORT = 32'd310;
  localparam logic [31:0] MESON_K_LONG  = 32'd130;
  localparam logic [7:0]  NUCLEUS_BASE  = 8'd100;

  typedef struct packed {
    logic [31:0] raw;
    kind_t       kind;
    logic        quark_ok;
    logic [7:0]  hs;
    logic [9:0]  z;
    logic [9:0]  a;
    logic [3:0]  q1;
    logic [3:0]  q2;
    logic [3:0]  q3;
    logic [3:0]  sd;
    logic [13:0] key;
  } digits_t;

  typedef struct packed {
    logic                ok;
    logic [5:0][11:0]    cnt;
    logic [5:0][11:0]    anti;
    logic signed [8:0]   spin;
  } decode_t;

  typedef struct packed {
    logic              hit;
    logic              low_pair;
    logic [3:0]        a;
    logic [3:0]        b;
    logic signed [8:0] spin;
  } bexc_t;

  function automatic bexc_t baryon_exception(input logic [13:0] key);
    bexc_t e;
    e = '{hit: 1'b1, low_pair: 1'b0, a: 4'd2, b: 4'd1, spin: 9'sd1};
    unique case (key)
      14'd3122, 14'd4122, 14'd5122, 14'd2122: e.spin = 9'sd1;
      14'd3124, 14'd2124: e.spin = 9'sd3;
      14'd3126, 14'd2126: e.spin = 9'sd5;
      14'd3128, 14'd2128: e.spin = 9'sd7;
      14'd4132, 14'd5132: e.a = 4'd3;
      14'd4232, 14'd5232: begin
        e.a = 4'd3;
        e.b = 4'd2;
      end
      14'd1212: e.low_pair = 1'b1;
      14'd1214: begin
        e.low_pair = 1'b1;
        e.spin = 9'sd3;
      end
      14'd1216: begin
        e.low_pair = 1'b1;
        e.spin = 9'sd5;
      end
      14'd1218: begin
        e.low_pair = 1'b1;
        e.spin = 9'sd7;
      end
      default: e.hit = 1'b0;
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/pcvd_classify.sv
`default_nettype none

module pcvd_classify #(
  parameter int FLAVOURS = 6
) (
  input  pcvd_pkg::digits_t dig,
  output pcvd_pkg::decode_t res
);
  import pcvd_pkg::*;

  logic [5:0][11:0] pos;
  logic [5:0][11:0] opp;
  logic             ok;
  logic signed [8:0] spin;
  logic [7:0]       ll;
  logic [3:0]       m2;
  logic [3:0]       m3;
  logic [3:0]       b1;
  logic [3:0]       b2;
  logic [3:0]       b3;
  logic [3:0]       flv;
  bexc_t            exc;

  assign flv = 4'(FLAVOURS);
  assign exc = baryon_exception(dig.key);

  always_comb begin
    pos  = '0;
    opp  = '0;
    ok   = 1'b1;
    ll   = dig.hs - NUCLEUS_BASE;
    m2   = dig.q2;
    m3   = dig.q3;
    b1   = dig.q1;
    b2   = dig.q2;
    b3   = dig.q3;
    if (dig.sd == 4'd0 && dig.hs != 8'd0) begin
      spin = $signed({1'b0, dig.hs}) - 9'sd1;
    end else begin
      spin = $signed({5'd0, dig.sd}) - 9'sd1;
    end
    unique case (dig.kind)
      K_NUCLEUS, K_ANTI_NUCLEUS: begin
        spin = 9'sd0;
        // Code layout is 10LZZZAAAI; L is the strange count.
        if (dig.hs < NUCLEUS_BASE || dig.a < 10'd2 ||
            (11'(dig.z) + 11'(ll)) > 11'(dig.a) || 10'(ll) > dig.a) begin
          ok = 1'b0;
        end else begin
          pos[0] = 12'({dig.a, 1'b0}) - 12'(dig.z) - 12'(ll);
          pos[1] = 12'(dig.z) + 12'(dig.a);
          pos[2] = 12'(ll);
        end
      end
      K_QUARK: begin
        ok = dig.quark_ok;
        if (ok) begin
          for (int f = 0; f < 6; f++) begin
            pos[f] = 12'(dig.key == 14'(f + 1));
          end
        end
      end
      K_DIQUARK: begin
        if (dig.q1 == 4'd0 || dig.q2 == 4'd0 || dig.q3 != 4'd0 ||
            dig.q1 < dig.q2 || dig.q1 > flv) begin
          ok = 1'b0;
        end else begin
          for (int f = 0; f < 6; f++) begin
            pos[f] = 12'(dig.q1 == 4'(f + 1)) + 12'(dig.q2 == 4'(f + 1));
          end
        end
      end
      K_MESON: begin
        if (dig.raw == MESON_K_SHORT) spin = 9'sd0;
        if (dig.raw == MESON_K_LONG) begin
          spin = 9'sd0;
          m2 = 4'd3;
          m3 = 4'd1;
        end
        if (dig.q1 != 4'd0 || m2 == 4'd0 || m3 == 4'd0 || m2 < m3 || m2 > flv) begin
          ok = 1'b0;
        end else begin
          // An odd heavier flavour is down-type, so it sits on the anti side.
          for (int f = 0; f < 6; f++) begin
            if (m2[0]) begin
              pos[f] = 12'(m3 == 4'(f + 1));
              opp[f] = 12'(m2 == 4'(f + 1));
            end else begin
              pos[f] = 12'(m2 == 4'(f + 1));
              opp[f] = 12'(m3 == 4'(f + 1));
            end
          end
        end
      end
      K_BARYON: begin
        if (dig.q1 == 4'd0 || dig.q2 == 4'd0 || dig.q3 == 4'd0) begin
          ok = 1'b0;
        end else begin
          if (exc.hit) begin
            spin = exc.spin;
            if (exc.low_pair) begin
              b1 = exc.a;
              b2 = exc.b;
            end else begin
              b2 = exc.a;
              b3 = exc.b;
            end
          end
          if (b1 < b2 || b2 < b3 || b1 < b3 || b1 > flv) begin
            ok = 1'b0;
          end else begin
            for (int f = 0; f < 6; f++) begin
              pos[f] = 12'(b1 == 4'(f + 1)) + 12'(b2 == 4'(f + 1)) +
                       12'(b3 == 4'(f + 1));
            end
          end
        end
      end
      K_GLUON, K_UNCHECKED: ok = 1'b1;
      default: ok = 1'b1;
    endcase
  end

  assign res.ok   = ok;
  assign res.cnt  = dig.raw[31] ? opp : pos;
  assign res.anti = dig.raw[31] ? pos : opp;
  assign res.spin = spin;

endmodule

`default_nettype wire

FILE: rtl/particle_code_validate_decode.sv
`default_nettype none

// Throughput: one request per cycle unless the output stalls; the seven
// stage registers each hold one request and advance independently, so
// bubbles are squeezed out.
// Reset: rst is synchronous and active high; it empties every stage.
module particle_code_validate_decode #(
  parameter int FLAVOURS = 6
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // particle_code [31:0], expected_charge_thirds [45:32]
  input  wire logic [47:0]  s_tdata,
  // operation [2:0]
  input  wire logic [2:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // checked_code [31:0], light_quark_counts [67:32], heavy_quark_counts [73:68],
  // light_antiquark_counts [109:74], heavy_antiquark_counts [115:110],
  // spin_code [124:116], charge_matches [125]
  output logic [127:0]      m_tdata
);
  import pcvd_pkg::*;

  logic [7:1] v;
  logic [8:1] en;

  always_comb begin
    en[8] = m_tready;
    for (int i = 7; i >= 1; i--) begin
      en[i] = !v[i] || en[i + 1];
    end
  end
  assign s_tready = en[1];
  assign m_tvalid = v[7];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) v[1] <= s_tvalid;
      for (int i = 2; i <= 7; i++) begin
        if (en[i]) v[i] <= v[i - 1];
      end
    end
  end

  // Stage 1: input register.
  logic [31:0]        s1_raw;
  kind_t              s1_kind;
  logic signed [13:0] s1_exp;
  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_raw  <= s_tdata[31:0];
      s1_kind <= kind_t'(s_tuser);
      s1_exp  <= $signed(s_tdata[45:32]);
    end
  end

  // Stage 2: magnitude times reciprocal of 10^4.
  logic [31:0] mag;
  logic [63:0] prod1;
  assign mag   = s1_raw[31] ? (~s1_raw + 32'd1) : s1_raw;
  assign prod1 = 64'(mag) * 64'(RECIP_1E4);

  logic [31:0]        s2_raw;
  kind_t              s2_kind;
  logic signed [13:0] s2_exp;
  logic [31:0]        s2_mag;
  logic               s2_qok;
  logic [17:0]        s2_test;
  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_raw  <= s1_raw;
      s2_kind <= s1_kind;
      s2_exp  <= s1_exp;
      s2_mag  <= mag;
      s2_qok  <= mag != 32'd0 && mag <= 32'(FLAVOURS);
      s2_test <= prod1[62:45];
    end
  end

  // Stage 3: correct the quotient by one where the remainder overflows.
  logic [31:0] r1;
  logic        c1;
  assign r1 = s2_mag - 32'(s2_test) * 32'd10000;
  assign c1 = r1 >= 32'd10000;

  logic [31:0]        s3_raw;
  kind_t              s3_kind;
  logic signed [13:0] s3_exp;
  logic               s3_qok;
  logic [17:0]        s3_t;
  logic [13:0]        s3_low4;
  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_raw  <= s2_raw;
      s3_kind <= s2_kind;
      s3_exp  <= s2_exp;
      s3_qok  <= s2_qok;
      s3_t    <= c1 ? s2_test + 18'd1 : s2_test;
      s3_low4 <= c1 ? 14'(r1 - 32'd10000) : 14'(r1);
    end
  end

  // Stage 4: upper group estimate and low digit quotients.
  logic [36:0] prod2;
  logic [27:0] p1000;
  logic [27:0] p100;
  logic [29:0] p10;
  assign prod2 = 37'(s3_t) * 37'(RECIP_1E3);
  assign p1000 = 28'(s3_low4) * 28'(RECIP_DIG1000);
  assign p100  = 28'(s3_low4) * 28'(RECIP_DIG100);
  assign p10   = 30'(s3_low4) * 30'(RECIP_DIG10);

  logic [31:0]        s4_raw;
  kind_t              s4_kind;
  logic signed [13:0] s4_exp;
  logic               s4_qok;
  logic [17:0]        s4_t;
  logic [7:0]         s4_hse;
  logic [13:0]        s4_low4;
  logic [3:0]         s4_d1000;
  logic [6:0]         s4_d100;
  logic [9:0]         s4_d10;
  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_raw   <= s3_raw;
      s4_kind  <= s3_kind;
      s4_exp   <= s3_exp;
      s4_qok   <= s3_qok;
      s4_t     <= s3_t;
      s4_hse   <= prod2[35:28];
      s4_low4  <= s3_low4;
      s4_d1000 <= p1000[26:23];
      s4_d100  <= p100[25:19];
      s4_d10   <= p10[28:19];
    end
  end

  // Stage 5: final upper group, nucleus Z field and single digits.
  logic [17:0] r2;
  logic        c2;
  assign r2 = s4_t - 18'(s4_hse) * 18'd1000;
  assign c2 = r2 >= 18'd1000;

  digits_t            s5_dig;
  logic signed [13:0] s5_exp;
  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_exp          <= s4_exp;
      s5_dig.raw      <= s4_raw;
      s5_dig.kind     <= s4_kind;
      s5_dig.quark_ok <= s4_qok;
      s5_dig.hs       <= c2 ? s4_hse + 8'd1 : s4_hse;
      s5_dig.z        <= c2 ? 10'(r2 - 18'd1000) : 10'(r2);
      s5_dig.a        <= s4_d10;
      s5_dig.q1       <= s4_d1000;
      s5_dig.q2       <= 4'(s4_d100 - 7'(s4_d1000) * 7'd10);
      s5_dig.q3       <= 4'(s4_d10 - 10'(s4_d100) * 10'd10);
      s5_dig.sd       <= 4'(s4_low4 - 14'(s4_d10) * 14'd10);
      s5_dig.key      <= s4_low4;
    end
  end

  // Stage 6: validation and content.
  decode_t res;
  pcvd_classify #(.FLAVOURS(FLAVOURS)) u_classify (
    .dig (s5_dig),
    .res (res)
  );

  decode_t            s6_res;
  logic [31:0]        s6_raw;
  logic signed [13:0] s6_exp;
  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_res <= res;
      s6_raw <= s5_dig.raw;
      s6_exp <= s5_exp;
    end
  end

  // Stage 7: charge of the content in thirds, and the output register.
  logic signed [15:0] total;
  always_comb begin
    total = '0;
    for (int f = 0; f < 6; f++) begin
      if (f % 2 == 1) begin
        total = total + $signed({3'd0, s6_res.cnt[f], 1'b0})
                      - $signed({3'd0, s6_res.anti[f], 1'b0});
      end else begin
        total = total - $signed({4'd0, s6_res.cnt[f]})
                      + $signed({4'd0, s6_res.anti[f]});
      end
    end
  end

  logic [31:0]       o_code;
  logic [35:0]       o_light;
  logic [5:0]        o_heavy;
  logic [35:0]       o_lanti;
  logic [5:0]        o_hanti;
  logic signed [8:0] o_spin;
  logic              o_match;
  always_ff @(posedge clk) begin
    if (en[7]) begin
      o_code  <= s6_res.ok ? s6_raw : 32'd0;
      o_light <= {s6_res.cnt[2], s6_res.cnt[1], s6_res.cnt[0]};
      o_heavy <= {s6_res.cnt[5][1:0], s6_res.cnt[4][1:0], s6_res.cnt[3][1:0]};
      o_lanti <= {s6_res.anti[2], s6_res.anti[1], s6_res.anti[0]};
      o_hanti <= {s6_res.anti[5][1:0], s6_res.anti[4][1:0], s6_res.anti[3][1:0]};
      o_spin  <= s6_res.spin;
      o_match <= total == 16'(s6_exp);
    end
  end

  assign m_tdata = {2'b00, o_match, o_spin, o_hanti, o_lanti, o_heavy, o_light, o_code};

`ifndef SYNTHESIS
  // A rejected code carries no quark content.
  a_reject_empty: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && o_code == 32'd0) |->
      (o_light == 36'd0 && o_heavy == 6'd0 && o_lanti == 36'd0 && o_hanti == 6'd0))
    else $error("rejected code with nonzero content");

  // With no result held, the pipeline can always take a request.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while output is empty");

  // The quotient correction keeps the low four digits below 10000.
  a_low4_range: assert property (@(posedge clk) disable iff (rst)
    v[3] |-> s3_low4 < 14'd10000)
    else $error("digit split out of range");
`endif

endmodule

`default_nettype wire
